### src/relativistic_particle_pusher_core_assert.svh
// Assertion macros for the relativistic particle pusher core.
`ifndef RELATIVISTIC_PARTICLE_PUSHER_CORE_ASSERT_SVH
`define RELATIVISTIC_PARTICLE_PUSHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define RPP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define RPP_ASSERT_IMP(label, clk, rst, ante, cons)
`define RPP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### src/rpp_pkg.sv
// Shared types, constants and helper functions of the particle pusher.
`timescale 1ns / 1ps
package rpp_pkg;
   localparam int FRAC_BITS = 16;
   localparam int WORD_W = 32;
   localparam int MASS_W = 31;
   localparam int PROD_W = 2 * WORD_W;
   localparam int NUM_W = 3 * WORD_W;
   localparam int TERM_W = 41;
   localparam int CAP_SHIFT = TERM_W;
   localparam int DIV_W = MASS_W + FRAC_BITS + 1;
   localparam int SRC_W = PROD_W;
   localparam int DIV_STEPS = TERM_W;
   localparam int SQRT_STEPS = WORD_W;
   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam int ADDR_W = 4;

   localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

   localparam logic [1:0] REG_REST_MASS = 2'd0;
   localparam logic [1:0] REG_LIGHT_SPEED = 2'd1;
   localparam logic [1:0] REG_FORCE_SCALE = 2'd2;

   typedef enum logic [1:0] {
      OP_KICK,
      OP_DRIFT,
      OP_SET_POS,
      OP_SET_MOM
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_ZERO_ENERGY,
      ST_SATURATED
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_NSUM,
      S_TERM,
      S_DIVRUN,
      S_ACC,
      S_SQMUL,
      S_SQADD,
      S_SQSTART,
      S_SQRT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic              sqrt_mode;
      logic [DIV_W-1:0]  rem_init;
      logic [SRC_W-1:0]  src;
      logic [DIV_W-1:0]  divisor;
   } iter_req_type;

   typedef struct packed {
      logic              done;
      logic [TERM_W-1:0] result;
   } iter_rsp_type;

   function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
      return v[WORD_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [TERM_W-1:0] cap_term(input logic [NUM_W-1:0] v);
      return (v > NUM_W'(TERM_CAP)) ? TERM_CAP : v[TERM_W-1:0];
   endfunction

   // Adds a signed term to a word and clamps; the top bit flags a clamp.
   function automatic logic [WORD_W:0] sat_add(input logic [WORD_W-1:0] base,
                                                input logic [TERM_W:0] delta);
      logic signed [TERM_W+1:0] s;
      s = $signed({{(TERM_W+2-WORD_W){base[WORD_W-1]}}, base})
        + $signed({delta[TERM_W], delta});
      if (s > $signed({{(TERM_W+3-WORD_W){1'b0}}, {(WORD_W-1){1'b1}}})) begin
         return {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
      end else if (s < -$signed({{(TERM_W+2-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}})) begin
         return {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
      end
      return {1'b0, s[WORD_W-1:0]};
   endfunction
endpackage

### src/rpp_iter.sv
// Shared serial unit: restoring division and digit-by-digit square root.
`timescale 1ns / 1ps
module rpp_iter (
   input  logic                 clock,
   input  logic                 reset,
   input  rpp_pkg::iter_req_type req,
   output rpp_pkg::iter_rsp_type rsp
);
   import rpp_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              mode_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [SRC_W-1:0]  src_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [TERM_W-1:0] res_ff;
   logic [DIV_W:0]    shv;
   logic [DIV_W:0]    opb;
   logic [DIV_W:0]    diff;
   logic              ge;

   always_comb begin
      if (mode_ff) begin
         shv = {{(DIV_W-35){1'b0}}, rem_ff[33:0], src_ff[SRC_W-1 -: 2]};
         opb = {{(DIV_W-33){1'b0}}, res_ff[WORD_W-1:0], 2'b01};
      end else begin
         shv = {rem_ff, src_ff[SRC_W-1]};
         opb = {1'b0, div_ff};
      end
      ge = (shv >= opb);
      diff = shv - opb;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         mode_ff <= req.sqrt_mode;
         rem_ff <= req.rem_init;
         src_ff <= req.src;
         div_ff <= req.divisor;
         res_ff <= '0;
         cnt_ff <= req.sqrt_mode ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_W-1:0] : shv[DIV_W-1:0];
         res_ff <= {res_ff[TERM_W-2:0], ge};
         src_ff <= mode_ff ? {src_ff[SRC_W-3:0], 2'b00} : {src_ff[SRC_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;
endmodule

### src/relativistic_particle_pusher_core.sv
// Top level of the relativistic particle pusher with its sequencer and registers.
//
// Usage: the request channel carries one word per operation: tuser holds the
// operation code (kick, drift, set position, set momentum) and tdata the three
// vector components and the scalar. Every accepted word produces exactly one
// response word holding the full particle state after the operation, with
// the status code in tuser. The CSR port holds rest mass, light speed and
// force scale and should only be written while the core is idle.
// Set position and a drift on zero energy go straight to the response; set
// momentum recomputes the energy, a kick updates the momentum and then the
// energy, and a drift moves the positions, lab time and proper time, skipping
// the divide for a term whose quotient overflows (that term is capped).
// The single 32x32 multiplier is shared; the serial divide/square-root unit
// gives one quotient or root bit per cycle (41 steps per divide, 32 per root).
// One operation is in flight at a time; req_tready is high only while the
// sequencer is idle. A finished response sits in an output register, so the
// next request is taken while it waits; when the receiver stalls, a second
// result waits in the sequencer until the register frees up.
// Reset clears the particle state to zero, restores the CSR defaults (all
// 1.0) and drops any pending response.
`timescale 1ns / 1ps
`include "relativistic_particle_pusher_core_assert.svh"
module relativistic_particle_pusher_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // vec_x, vec_y, vec_z, scalar
   input  logic [4*rpp_pkg::WORD_W-1:0] req_tdata,
   // op
   input  logic [1:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // now_lab, pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, energy_out, proper_elapsed, pad
   output logic [9*rpp_pkg::WORD_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                   rsp_tuser,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rpp_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import rpp_pkg::*;

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [MASS_W-1:0] mass_ff, light_ff, fscale_ff;
   logic [WORD_W-1:0] vec_ff [3];
   logic [WORD_W-1:0] dt_ff;
   logic [WORD_W-1:0] lab_ff, prop_ff;
   logic [WORD_W-1:0] pos_ff [3];
   logic [WORD_W-1:0] mom_ff [3];
   logic [MASS_W-1:0] energy_ff;
   logic [1:0]        term_ff;
   logic              sat_ff, zero_ff, sgn_ff;
   logic [PROD_W-1:0] ab_ff, lo_ff, hi_ff, sq_acc_ff;
   logic [NUM_W-1:0]  n_ff;
   logic [TERM_W-1:0] tmag_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [9*WORD_W-1:0] rsp_data_ff;
   logic [1:0]        rsp_user_ff;

   logic              accept, csr_write, rsp_load, last_term, div_ovf;
   logic [1:0]        ix, sq_ix;
   logic [WORD_W-1:0] op_a, op_b, op_c, sq_op, mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [DIV_W-1:0]  divisor;
   logic              op_sgn;
   logic [TERM_W:0]   term_s;
   logic [WORD_W:0]   acc_res, lab_res;
   logic [WORD_W-1:0] acc_base;
   logic [WORD_W-1:0] root;
   status_type        status;
   iter_req_type      iter_req;
   iter_rsp_type      iter_rsp;

   rpp_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (iter_req),
      .rsp   (iter_rsp)
   );

   assign accept = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign ix = (term_ff == 2'd3) ? 2'd0 : term_ff;
   assign sq_ix = term_ff - 2'd1;
   assign last_term = (op_ff == OP_KICK) ? (term_ff == 2'd2) : (term_ff == 2'd3);

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_REST_MASS:   csr_prdata = {1'b0, mass_ff};
         REG_LIGHT_SPEED: csr_prdata = {1'b0, light_ff};
         REG_FORCE_SCALE: csr_prdata = {1'b0, fscale_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (op_ff == OP_KICK) begin
         op_a = mag32(vec_ff[ix]);
         op_b = mag32(dt_ff);
         op_c = {1'b0, fscale_ff};
         op_sgn = vec_ff[ix][WORD_W-1] ^ dt_ff[WORD_W-1];
      end else if (term_ff != 2'd3) begin
         op_a = {1'b0, light_ff};
         op_b = mag32(mom_ff[ix]);
         op_c = mag32(dt_ff);
         op_sgn = mom_ff[ix][WORD_W-1] ^ dt_ff[WORD_W-1];
      end else begin
         op_a = mag32(dt_ff);
         op_b = {1'b0, mass_ff};
         op_c = WORD_W'(1);
         op_sgn = dt_ff[WORD_W-1];
      end
      sq_op = (term_ff == 2'd0) ? {1'b0, mass_ff} : mag32(mom_ff[sq_ix]);
      unique case (state_ff)
         S_MUL1: begin
            mul_a = op_a;
            mul_b = op_b;
         end
         S_MUL2: begin
            mul_a = ab_ff[WORD_W-1:0];
            mul_b = op_c;
         end
         S_MUL3: begin
            mul_a = ab_ff[PROD_W-1:WORD_W];
            mul_b = op_c;
         end
         S_SQMUL: begin
            mul_a = sq_op;
            mul_b = sq_op;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      divisor = (term_ff == 2'd3) ? DIV_W'(energy_ff)
                                  : DIV_W'({energy_ff, {FRAC_BITS{1'b0}}});
      div_ovf = n_ff[NUM_W-1:CAP_SHIFT] >= (NUM_W-CAP_SHIFT)'(divisor);
      iter_req.start = 1'b0;
      iter_req.sqrt_mode = 1'b0;
      iter_req.rem_init = n_ff[CAP_SHIFT +: DIV_W];
      iter_req.src = {n_ff[CAP_SHIFT-1:0], {(SRC_W-CAP_SHIFT){1'b0}}};
      iter_req.divisor = divisor;
      if (state_ff == S_TERM && op_ff == OP_DRIFT && !div_ovf) begin
         iter_req.start = 1'b1;
      end else if (state_ff == S_SQSTART) begin
         iter_req.start = 1'b1;
         iter_req.sqrt_mode = 1'b1;
         iter_req.rem_init = '0;
         iter_req.src = sq_acc_ff;
         iter_req.divisor = '0;
      end
   end

   always_comb begin
      term_s = sgn_ff ? -{1'b0, tmag_ff} : {1'b0, tmag_ff};
      if (op_ff == OP_KICK) begin
         acc_base = mom_ff[ix];
      end else if (term_ff == 2'd3) begin
         acc_base = prop_ff;
      end else begin
         acc_base = pos_ff[ix];
      end
      acc_res = sat_add(acc_base, term_s);
      lab_res = sat_add(lab_ff, {{(TERM_W+1-WORD_W){dt_ff[WORD_W-1]}}, dt_ff});
      root = iter_rsp.result[WORD_W-1:0];
      if (zero_ff) begin
         status = ST_ZERO_ENERGY;
      end else if (sat_ff) begin
         status = ST_SATURATED;
      end else begin
         status = ST_OK;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (op_type'(req_tuser))
                  OP_KICK:    state_in = S_MUL1;
                  OP_DRIFT:   state_in = (energy_ff == '0) ? S_DONE : S_MUL1;
                  OP_SET_POS: state_in = S_DONE;
                  OP_SET_MOM: state_in = S_SQMUL;
               endcase
            end
         end
         S_MUL1:    state_in = S_MUL2;
         S_MUL2:    state_in = S_MUL3;
         S_MUL3:    state_in = S_NSUM;
         S_NSUM:    state_in = S_TERM;
         S_TERM: begin
            if (op_ff == OP_KICK || div_ovf) begin
               state_in = S_ACC;
            end else begin
               state_in = S_DIVRUN;
            end
         end
         S_DIVRUN:  state_in = iter_rsp.done ? S_ACC : S_DIVRUN;
         S_ACC: begin
            if (!last_term) begin
               state_in = S_MUL1;
            end else if (op_ff == OP_KICK) begin
               state_in = S_SQMUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SQMUL:   state_in = S_SQADD;
         S_SQADD:   state_in = (term_ff == 2'd3) ? S_SQSTART : S_SQMUL;
         S_SQSTART: state_in = S_SQRT;
         S_SQRT:    state_in = iter_rsp.done ? S_DONE : S_SQRT;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= MASS_W'(65536);
         light_ff <= MASS_W'(65536);
         fscale_ff <= MASS_W'(65536);
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_REST_MASS:   mass_ff <= csr_pwdata[MASS_W-1:0];
            REG_LIGHT_SPEED: light_ff <= csr_pwdata[MASS_W-1:0];
            REG_FORCE_SCALE: fscale_ff <= csr_pwdata[MASS_W-1:0];
            default: ;
         endcase
      end
   end

   // Particle state.
   always_ff @(posedge clock) begin
      if (reset) begin
         lab_ff <= '0;
         prop_ff <= '0;
         energy_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            mom_ff[i] <= '0;
         end
      end else begin
         if (accept && op_type'(req_tuser) == OP_SET_POS) begin
            lab_ff <= req_tdata[3*WORD_W +: WORD_W];
            for (int i = 0; i < 3; i++) begin
               pos_ff[i] <= req_tdata[i*WORD_W +: WORD_W];
            end
         end
         if (accept && op_type'(req_tuser) == OP_SET_MOM) begin
            for (int i = 0; i < 3; i++) begin
               mom_ff[i] <= req_tdata[i*WORD_W +: WORD_W];
            end
         end
         if (state_ff == S_ACC) begin
            if (op_ff == OP_KICK) begin
               mom_ff[ix] <= acc_res[WORD_W-1:0];
            end else if (term_ff == 2'd3) begin
               prop_ff <= acc_res[WORD_W-1:0];
               lab_ff <= lab_res[WORD_W-1:0];
            end else begin
               pos_ff[ix] <= acc_res[WORD_W-1:0];
            end
         end
         if (state_ff == S_SQRT && iter_rsp.done) begin
            energy_ff <= root[WORD_W-1] ? {MASS_W{1'b1}} : root[MASS_W-1:0];
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_tuser);
         for (int i = 0; i < 3; i++) begin
            vec_ff[i] <= req_tdata[i*WORD_W +: WORD_W];
         end
         dt_ff <= req_tdata[3*WORD_W +: WORD_W];
         term_ff <= '0;
         sat_ff <= 1'b0;
         zero_ff <= (op_type'(req_tuser) == OP_DRIFT) && (energy_ff == '0);
         sq_acc_ff <= '0;
      end
      unique case (state_ff)
         S_MUL1: begin
            ab_ff <= mul_p;
            sgn_ff <= op_sgn;
         end
         S_MUL2:  lo_ff <= mul_p;
         S_MUL3:  hi_ff <= mul_p;
         S_NSUM:  n_ff <= {hi_ff, {WORD_W{1'b0}}} + NUM_W'(lo_ff);
         S_TERM: begin
            if (op_ff == OP_KICK) begin
               tmag_ff <= cap_term(n_ff >> (2 * FRAC_BITS));
            end else if (div_ovf) begin
               tmag_ff <= TERM_CAP;
            end
         end
         S_DIVRUN: begin
            if (iter_rsp.done) begin
               tmag_ff <= cap_term(NUM_W'(iter_rsp.result));
            end
         end
         S_ACC: begin
            if (acc_res[WORD_W] || (op_ff == OP_DRIFT && term_ff == 2'd3 && lab_res[WORD_W])) begin
               sat_ff <= 1'b1;
            end
            term_ff <= last_term ? 2'd0 : term_ff + 2'd1;
            if (last_term) begin
               sq_acc_ff <= '0;
            end
         end
         S_SQMUL: lo_ff <= mul_p;
         S_SQADD: begin
            sq_acc_ff <= sq_acc_ff + lo_ff;
            term_ff <= term_ff + 2'd1;
         end
         S_SQRT: begin
            if (iter_rsp.done && root[WORD_W-1]) begin
               sat_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, prop_ff, energy_ff, mom_ff[2], mom_ff[1], mom_ff[0],
                         pos_ff[2], pos_ff[1], pos_ff[0], lab_ff};
         rsp_user_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   `RPP_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `RPP_ASSERT_IMP(a_drift_energy_nonzero, clock, reset, state_ff == S_DIVRUN, energy_ff != '0)
   `RPP_ASSERT_IMP(a_iter_done_awaited, clock, reset, iter_rsp.done,
                   state_ff == S_DIVRUN || state_ff == S_SQRT)
endmodule

### bench/relativistic_particle_pusher_core_tb.sv
// Self-checking testbench of the relativistic particle pusher core.
`timescale 1ns / 1ps
module relativistic_particle_pusher_core_tb;
   import rpp_pkg::*;

   typedef struct {
      logic [31:0] lab, px, py, pz, mx, my, mz;
      logic [30:0] en;
      logic [31:0] prop;
      status_type  st;
   } particle_word_type;

   typedef struct {
      op_type      op;
      logic [31:0] x, y, z, s;
      bit          known;
      status_type  k_st;
      logic [30:0] k_en;
   } plan_row_type;

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] PMAX = 32'h7fff_ffff;
   localparam logic [31:0] NMIN = 32'h8000_0000;
   localparam int PLAN_N = 21;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [127:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid, rsp_tready;
   logic [287:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   logic         csr_pready;

   longint cfg_mass, cfg_light, cfg_force;
   longint lab_q, proper_q;
   longint pos_q [3];
   longint mom_q [3];
   longint energy_q;
   bit     clamp_seen;

   particle_word_type pending [$];
   int     errors = 0;
   int     words_seen = 0;
   int     status_seen [3] = '{0, 0, 0};
   int     items_sent = 0;
   bit     quiet = 0;
   bit     valid_up = 0;
   int     stall_cnt = 0;

   relativistic_particle_pusher_core uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic longint scaled_term(longint a, longint b, longint c, logic [63:0] d);
      logic [127:0] num, q;
      logic [31:0]  ma, mb, mc;
      bit           neg;
      neg = (a < 0) ^ (b < 0) ^ (c < 0);
      ma = 32'((a < 0) ? -a : a);
      mb = 32'((b < 0) ? -b : b);
      mc = 32'((c < 0) ? -c : c);
      num = {96'b0, ma} * {96'b0, mb} * {96'b0, mc};
      q = num / {64'b0, d};
      if (q > 128'h100_0000_0000) q = 128'h100_0000_0000;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         clamp_seen = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clamp_seen = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] x);
      logic [63:0] r, pw;
      r = 0;
      pw = 64'h4000_0000_0000_0000;
      while (pw > x) pw >>= 2;
      while (pw != 0) begin
         if (x >= r + pw) begin
            x -= r + pw;
            r = (r >> 1) + pw;
         end else begin
            r >>= 1;
         end
         pw >>= 2;
      end
      return r;
   endfunction

   function void refresh_energy();
      logic [63:0] sum, e;
      logic [31:0] m;
      sum = 64'(cfg_mass) * 64'(cfg_mass);
      for (int i = 0; i < 3; i++) begin
         m = 32'((mom_q[i] < 0) ? -mom_q[i] : mom_q[i]);
         sum += 64'(m) * 64'(m);
      end
      e = root64(sum);
      if (e > 64'h7fff_ffff) begin
         e = 64'h7fff_ffff;
         clamp_seen = 1;
      end
      energy_q = e;
   endfunction

   function particle_word_type advance_particle(op_type op, logic [31:0] x, y, z, s);
      particle_word_type r;
      longint v [3];
      longint dt;
      v[0] = longint'($signed(x));
      v[1] = longint'($signed(y));
      v[2] = longint'($signed(z));
      dt = longint'($signed(s));
      clamp_seen = 0;
      r.st = ST_OK;
      case (op)
         OP_KICK: begin
            for (int i = 0; i < 3; i++)
               mom_q[i] = clamp32(mom_q[i] + scaled_term(v[i], dt, cfg_force, 64'd1 << 32));
            refresh_energy();
         end
         OP_DRIFT: begin
            if (energy_q == 0) begin
               r.st = ST_ZERO_ENERGY;
            end else begin
               for (int i = 0; i < 3; i++)
                  pos_q[i] = clamp32(pos_q[i] + scaled_term(cfg_light, mom_q[i], dt,
                                                            64'(energy_q) << 16));
               lab_q = clamp32(lab_q + dt);
               proper_q = clamp32(proper_q + scaled_term(dt, cfg_mass, 1, 64'(energy_q)));
            end
         end
         OP_SET_POS: begin
            lab_q = dt;
            for (int i = 0; i < 3; i++) pos_q[i] = v[i];
         end
         default: begin
            for (int i = 0; i < 3; i++) mom_q[i] = v[i];
            refresh_energy();
         end
      endcase
      if (r.st == ST_OK && clamp_seen) r.st = ST_SATURATED;
      r.lab = lab_q[31:0];
      r.px = pos_q[0][31:0];
      r.py = pos_q[1][31:0];
      r.pz = pos_q[2][31:0];
      r.mx = mom_q[0][31:0];
      r.my = mom_q[1][31:0];
      r.mz = mom_q[2][31:0];
      r.en = energy_q[30:0];
      r.prop = proper_q[31:0];
      return r;
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
   endtask

   task compare(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(what, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_cnt <= 0;
      end else if (stall_cnt != 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_tready <= (stall_cnt == 1);
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_cnt <= $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      particle_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (pending.size() == 0) begin
            report("unexpected word", rsp_tdata[31:0], 32'h0);
         end else begin
            w = pending.pop_front();
            compare("now_lab", rsp_tdata[31:0], w.lab);
            compare("pos_x", rsp_tdata[63:32], w.px);
            compare("pos_y", rsp_tdata[95:64], w.py);
            compare("pos_z", rsp_tdata[127:96], w.pz);
            compare("mom_x", rsp_tdata[159:128], w.mx);
            compare("mom_y", rsp_tdata[191:160], w.my);
            compare("mom_z", rsp_tdata[223:192], w.mz);
            compare("energy_out", {1'b0, rsp_tdata[254:224]}, {1'b0, w.en});
            compare("proper_elapsed", rsp_tdata[286:255], w.prop);
            compare("status", {30'b0, rsp_tuser}, {30'b0, w.st});
            if (rsp_tuser < 3) status_seen[rsp_tuser]++;
         end
      end
   end

   task push_item(op_type op, logic [31:0] x, y, z, s,
                  bit known = 0, status_type kst = ST_OK, logic [30:0] ken = 0);
      particle_word_type w;
      req_tuser <= op;
      req_tdata <= {s, z, y, x};
      req_tvalid <= 1'b1;
      valid_up = 1;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      w = advance_particle(op, x, y, z, s);
      if (known) begin
         w.st = kst;
         w.en = ken;
      end
      pending = {pending, w};
      items_sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         valid_up = 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task drain();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 0;
      end
      while (pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_REST_MASS: cfg_mass = longint'(value[30:0]);
         REG_LIGHT_SPEED: cfg_light = longint'(value[30:0]);
         default: cfg_force = longint'(value[30:0]);
      endcase
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1, 2: return $urandom_range(0, 32'h0007_ffff) - 32'h0004_0000;
         3: return $urandom_range(0, 32'h007f_ffff) - 32'h0040_0000;
         4: begin
            case ($urandom_range(0, 4))
               0: return 32'h0;
               1: return 32'h1;
               2: return PMAX;
               3: return NMIN;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom_range(0, 32'h0001_ffff) - ONE;
      endcase
   endfunction

   function automatic logic [31:0] pick_config();
      case ($urandom_range(0, 2))
         0: return $urandom & 32'h7fff_ffff;
         1: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
      endcase
   endfunction

   plan_row_type plan [PLAN_N] = '{
      '{OP_DRIFT, 0, 0, 0, ONE, 1, ST_ZERO_ENERGY, 31'h0},
      '{OP_SET_MOM, 0, 0, 0, 0, 1, ST_OK, 31'h10000},
      '{OP_SET_POS, PMAX, PMAX, PMAX, PMAX, 1, ST_OK, 31'h10000},
      '{OP_SET_POS, NMIN, NMIN, NMIN, NMIN, 1, ST_OK, 31'h10000},
      '{OP_SET_MOM, PMAX, PMAX, PMAX, 0, 1, ST_SATURATED, 31'h7fffffff},
      '{OP_SET_MOM, NMIN, NMIN, NMIN, PMAX, 1, ST_SATURATED, 31'h7fffffff},
      '{OP_DRIFT, 0, 0, 0, ONE, 0, ST_OK, 0},
      '{OP_SET_MOM, 0, 0, 0, 0, 1, ST_OK, 31'h10000},
      '{OP_SET_POS, 0, 0, 0, 0, 1, ST_OK, 31'h10000},
      '{OP_KICK, ONE, 32'hfffe_0000, 32'h0000_8000, 32'h0000_8000, 0, ST_OK, 0},
      '{OP_DRIFT, 0, 0, 0, 32'h0000_4000, 0, ST_OK, 0},
      '{OP_DRIFT, 0, 0, 0, 32'hffff_0000, 0, ST_OK, 0},
      '{OP_KICK, PMAX, PMAX, PMAX, PMAX, 1, ST_SATURATED, 31'h7fffffff},
      '{OP_KICK, NMIN, NMIN, NMIN, PMAX, 1, ST_SATURATED, 31'h7fffffff},
      '{OP_DRIFT, 0, 0, 0, PMAX, 0, ST_OK, 0},
      '{OP_DRIFT, 0, 0, 0, NMIN, 0, ST_OK, 0},
      '{OP_SET_MOM, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, ST_OK, 0},
      '{OP_KICK, ONE, ONE, ONE, 0, 0, ST_OK, 0},
      '{OP_SET_POS, 32'h0001_8000, 32'hfffd_8000, 32'h0003_0000, 32'h000a_0000, 0, ST_OK, 0},
      '{OP_DRIFT, 0, 0, 0, ONE, 0, ST_OK, 0},
      '{OP_SET_MOM, 32'hffff_0000, 32'h0002_0000, 32'hfffd_0000, 32'h1234_5678, 0, ST_OK, 0}
   };

   initial begin
      logic [31:0] phase_cfg [7][3];
      phase_cfg = '{
         '{ONE, ONE, ONE},
         '{PMAX, PMAX, PMAX},
         '{0, 0, 0},
         '{32'h0, 32'h0, 32'h0},
         '{32'h0000_8000, 32'h0002_0000, 32'h0000_028f},
         '{32'h0, 32'h0, 32'h0},
         '{ONE, ONE, ONE}
      };
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_mass = ONE;
      cfg_light = ONE;
      cfg_force = ONE;
      lab_q = 0;
      proper_q = 0;
      energy_q = 0;
      for (int i = 0; i < 3; i++) begin
         pos_q[i] = 0;
         mom_q[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < PLAN_N; k++)
         push_item(plan[k].op, plan[k].x, plan[k].y, plan[k].z, plan[k].s,
                   plan[k].known, plan[k].k_st, plan[k].k_en);
      drain();

      for (int p = 0; p < 7; p++) begin
         if (p == 3 || p == 5)
            for (int r = 0; r < 3; r++) phase_cfg[p][r] = pick_config();
         quiet = (p == 6);
         csr_write(REG_REST_MASS, phase_cfg[p][0]);
         csr_write(REG_LIGHT_SPEED, phase_cfg[p][1]);
         csr_write(REG_FORCE_SCALE, phase_cfg[p][2]);
         @(posedge clock);
         push_item(OP_SET_MOM, 0, 0, 0, 0);
         push_item(OP_DRIFT, 0, 0, 0, ONE);
         for (int n = 0; n < 160; n++) begin
            if (p == 3 && n % 40 == 39) drain();
            push_item(op_type'($urandom_range(0, 3)), pick_value(), pick_value(),
                      pick_value(), pick_value());
         end
         drain();
      end

      repeat (300) @(posedge clock);
      $display("Sent %0d words over 7 register settings; %0d results checked.",
               items_sent, words_seen);
      $display("Status counts: ok %0d, zero energy %0d, saturated %0d.",
               status_seen[0], status_seen[1], status_seen[2]);
      if (errors == 0 && pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
